// ===== rtl/glyph_quad_text_layout_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_TOP_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define GQTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define GQTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also watches the reset cycles.
`define GQTL_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gqtl_pkg.sv =====
package gqtl_pkg;

  typedef enum logic [1:0] {
    KIND_TR_WRITE    = 2'd0,
    KIND_GLYPH_WRITE = 2'd1,
    KIND_START       = 2'd2,
    KIND_CHAR        = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SCALE        = 2'd0,
    CFG_FONT_HEIGHT  = 2'd1,
    CFG_LINE_ADVANCE = 2'd2,
    CFG_MAX_CODE     = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] NEWLINE_CODE = 16'd10;
  localparam logic [19:0] PIXEL_MASK   = 20'hFFFF0;

  typedef struct packed {
    kind_t              kind;
    logic        [15:0] index;
    logic        [7:0]  glyph_number;
    logic        [15:0] tex_u1;
    logic        [15:0] tex_v1;
    logic        [15:0] tex_u2;
    logic        [15:0] tex_v2;
    logic signed [15:0] glyph_offset;
    logic signed [15:0] glyph_width;
    logic signed [15:0] glyph_advance;
    logic signed [19:0] start_x;
    logic signed [19:0] start_y;
  } in_word_t;

  typedef struct packed {
    logic signed [19:0] vert_x;
    logic signed [19:0] vert_y;
    logic        [15:0] vert_u;
    logic        [15:0] vert_v;
    logic               quad_last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] u1;
    logic [15:0] v1;
    logic [15:0] u2;
    logic [15:0] v2;
    logic [15:0] off;
    logic [15:0] wid;
    logic [15:0] adv;
  } glyph_entry_t;

  // Whole pixels, sign extended, times scale, into 4-fraction-bit fixed point.
  function automatic logic [19:0] pix_to_fixed(input logic [15:0] raw, input logic [1:0] sc);
    logic [19:0] ext;
    logic [19:0] prod;
    ext  = {{4{raw[15]}}, raw};
    prod = 20'(ext * {18'd0, sc});
    return {prod[15:0], 4'd0};
  endfunction

endpackage

// ===== rtl/gqtl_tables.sv =====
module gqtl_tables #(
  parameter int CODE_DEPTH  = 256,
  parameter int GLYPH_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  gqtl_pkg::in_word_t            wr_word,
  input  logic                          tr_ren,
  output logic [7:0]                    tr_rdata_r,
  input  logic                          glyph_ren,
  input  logic [$clog2(GLYPH_DEPTH)-1:0] glyph_raddr,
  output gqtl_pkg::glyph_entry_t        glyph_rdata_r
);
  import gqtl_pkg::*;

  localparam int CAW = $clog2(CODE_DEPTH);
  localparam int GAW = $clog2(GLYPH_DEPTH);

  logic [7:0]   tr_mem    [CODE_DEPTH];
  glyph_entry_t glyph_mem [GLYPH_DEPTH];

  logic         tr_we;
  logic         glyph_we;
  glyph_entry_t glyph_wdata;

  // Drop writes aimed past the end of either table.
  assign tr_we    = wr_en && (wr_word.kind == KIND_TR_WRITE) &&
                    ({16'd0, wr_word.index} < 32'(CODE_DEPTH));
  assign glyph_we = wr_en && (wr_word.kind == KIND_GLYPH_WRITE) &&
                    ({16'd0, wr_word.index} < 32'(GLYPH_DEPTH));

  assign glyph_wdata = '{u1:  wr_word.tex_u1,
                         v1:  wr_word.tex_v1,
                         u2:  wr_word.tex_u2,
                         v2:  wr_word.tex_v2,
                         off: wr_word.glyph_offset,
                         wid: wr_word.glyph_width,
                         adv: wr_word.glyph_advance};

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tr_mem[wr_word.index[CAW-1:0]] <= wr_word.glyph_number;
    end
    if (tr_ren) begin
      tr_rdata_r <= tr_mem[wr_word.index[CAW-1:0]];
    end
  end

  // Read returns the old entry when a write hits the same slot in the same cycle.
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[wr_word.index[GAW-1:0]] <= glyph_wdata;
    end
    if (glyph_ren) begin
      glyph_rdata_r <= glyph_mem[glyph_raddr];
    end
  end

endmodule

// ===== rtl/glyph_quad_text_layout_top.sv =====
// Bitmap-font text layout: table write and start words pass through and produce nothing;
// a character word produces one quad of four vertex words, so text flows no faster than
// the single vertex output carries four vertex words per character. Words run through the
// pipe stages s1 and s2: the translator memory is read as a word enters, the glyph memory
// as the word moves from s1 to s2, and the quad is formed and the cursor moved as the word
// leaves s2, after which a quad buffer plays the four vertices out while the next character
// is already being looked up. Both tables come up undefined and need no clearing; the
// configuration port is always ready and must be written only while the block is idle.
module glyph_quad_text_layout_top #(
  parameter int CODE_DEPTH  = 256,
  parameter int GLYPH_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gqtl_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gqtl_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  gqtl_pkg::cfg_reg_t   cfg_index,
  input  logic [15:0]          cfg_data
);
  import gqtl_pkg::*;

  localparam int GAW = $clog2(GLYPH_DEPTH);

  // Configuration registers
  logic [1:0]  scale_r;
  logic [15:0] font_height_r;
  logic [15:0] line_advance_r;
  logic [7:0]  max_code_r;

  // Cursor state
  logic [19:0] cursor_x_r, cursor_x_nxt;
  logic [19:0] cursor_y_r, cursor_y_nxt;
  logic [19:0] origin_x_r, origin_x_nxt;

  // Pipe stages: s1 holds translator data, s2 holds glyph data
  logic         s1_valid_r, s2_valid_r;
  in_word_t     s1_word_r, s2_word_r;
  logic [7:0]   tr_rdata;
  glyph_entry_t glyph_rdata;

  // Quad buffer
  logic        q_valid_r;
  logic [1:0]  q_cnt_r;
  logic        q_nl_r;
  logic [19:0] q_x0_r, q_x1_r, q_y0_r, q_y1_r;
  logic [15:0] q_u1_r, q_u2_r, q_v1_r, q_v2_r;

  logic        q_free, adv, in_acc, out_acc, s2_char, s2_nl;
  logic [7:0]  glyph_sel;
  logic [16:0] glyph_wide;
  logic [19:0] cx_off, x1_calc, y1_calc, h_fx, cx_after;

  assign cfg_ready = 1'b1;

  // The buffer frees up as its fourth vertex leaves.
  assign q_free  = !q_valid_r || (q_cnt_r == 2'd3 && !out_stall);
  assign s2_char = s2_valid_r && (s2_word_r.kind == KIND_CHAR);
  assign adv     = !s2_char || q_free;
  assign in_stall = !adv;
  assign in_acc  = in_valid && adv;
  assign out_acc = out_valid && !out_stall;

  // Glyph selection: codes above max_code or past either table use glyph 0.
  always_comb begin
    glyph_sel = 8'd0;
    if ({8'd0, s1_word_r.index} <= {16'd0, max_code_r} &&
        {16'd0, s1_word_r.index} < 32'(CODE_DEPTH)) begin
      glyph_sel = tr_rdata;
    end
    if ({24'd0, glyph_sel} >= 32'(GLYPH_DEPTH)) begin
      glyph_sel = 8'd0;
    end
    glyph_wide = {9'd0, glyph_sel};
  end

  gqtl_tables #(
    .CODE_DEPTH  (CODE_DEPTH),
    .GLYPH_DEPTH (GLYPH_DEPTH)
  ) u_tables (
    .clk           (clk),
    .wr_en         (in_acc),
    .wr_word       (in_word),
    .tr_ren        (adv),
    .tr_rdata_r    (tr_rdata),
    .glyph_ren     (adv),
    .glyph_raddr   (glyph_wide[GAW-1:0]),
    .glyph_rdata_r (glyph_rdata)
  );

  // Quad geometry and cursor motion for the word in s2
  assign s2_nl    = s2_word_r.index == NEWLINE_CODE;
  assign cx_off   = cursor_x_r + pix_to_fixed(glyph_rdata.off, scale_r);
  assign x1_calc  = cx_off + pix_to_fixed(glyph_rdata.wid, scale_r);
  assign h_fx     = 20'({4'd0, font_height_r} * {18'd0, scale_r});
  assign y1_calc  = cursor_y_r + h_fx;
  assign cx_after = cx_off + pix_to_fixed(glyph_rdata.adv, scale_r);

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    origin_x_nxt = origin_x_r;
    if (s2_valid_r && s2_word_r.kind == KIND_START) begin
      cursor_x_nxt = s2_word_r.start_x & PIXEL_MASK;
      cursor_y_nxt = s2_word_r.start_y & PIXEL_MASK;
      origin_x_nxt = s2_word_r.start_x;
    end else if (s2_char && s2_nl) begin
      // Newline: back to the line origin, step down by the scaled line advance.
      cursor_x_nxt = origin_x_r;
      cursor_y_nxt = cursor_y_r + 20'({4'd0, line_advance_r} * {18'd0, scale_r});
    end else if (s2_char) begin
      cursor_x_nxt = cx_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r        <= 2'd1;
      font_height_r  <= '0;
      line_advance_r <= '0;
      max_code_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCALE:        scale_r        <= cfg_data[1:0];
        CFG_FONT_HEIGHT:  font_height_r  <= cfg_data;
        CFG_LINE_ADVANCE: line_advance_r <= cfg_data;
        CFG_MAX_CODE:     max_code_r     <= cfg_data[7:0];
      endcase
    end
  end

  // Advance the pipe; retire the s2 word into the cursor and quad buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      origin_x_r <= '0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      origin_x_r <= origin_x_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_word_r <= in_word;
      s2_word_r <= s1_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      q_cnt_r   <= '0;
    end else priority if (adv && s2_char) begin
      q_valid_r <= 1'b1;
      q_cnt_r   <= '0;
    end else if (out_acc) begin
      if (q_cnt_r == 2'd3) begin
        q_valid_r <= 1'b0;
      end
      q_cnt_r <= q_cnt_r + 2'd1;
    end else begin
      // Hold the buffer while the receiver stalls or nothing is queued.
      q_cnt_r <= q_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_char) begin
      q_nl_r <= s2_nl;
      q_x0_r <= cx_off;
      q_x1_r <= x1_calc;
      q_y0_r <= cursor_y_r;
      q_y1_r <= y1_calc;
      q_u1_r <= glyph_rdata.u1;
      q_u2_r <= glyph_rdata.u2;
      q_v1_r <= glyph_rdata.v1;
      q_v2_r <= glyph_rdata.v2;
    end
  end

  // Corner order: top-left, top-right, bottom-right, bottom-left.
  assign out_valid = q_valid_r;

  always_comb begin
    out_word = '0;
    unique case (q_cnt_r)
      2'd0: out_word = '{vert_x: q_x0_r, vert_y: q_y0_r, vert_u: q_u1_r, vert_v: q_v1_r,
                         quad_last: 1'b0};
      2'd1: out_word = '{vert_x: q_x1_r, vert_y: q_y0_r, vert_u: q_u2_r, vert_v: q_v1_r,
                         quad_last: 1'b0};
      2'd2: out_word = '{vert_x: q_x1_r, vert_y: q_y1_r, vert_u: q_u2_r, vert_v: q_v2_r,
                         quad_last: 1'b0};
      2'd3: out_word = '{vert_x: q_x0_r, vert_y: q_y1_r, vert_u: q_u1_r, vert_v: q_v2_r,
                         quad_last: 1'b1};
    endcase
    // Blank the quad for a newline, keep the end marker.
    if (q_nl_r) begin
      out_word.vert_x = '0;
      out_word.vert_y = '0;
      out_word.vert_u = '0;
      out_word.vert_v = '0;
    end
  end

endmodule

// ===== rtl/gqtl_checker.sv =====
`include "glyph_quad_text_layout_top_defines.svh"

module gqtl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input gqtl_pkg::out_word_t out_word
);
  import gqtl_pkg::*;

  logic [1:0] vtx_cnt_r;

  // Count accepted vertex words to know where each quad should end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_cnt_r <= '0;
    end else if (out_valid && !out_stall) begin
      vtx_cnt_r <= vtx_cnt_r + 2'd1;
    end
  end

  `GQTL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled vertex word changed")
  `GQTL_ASSERT_IMP(a_last_pos, out_valid, out_word.quad_last == (vtx_cnt_r == 2'd3), "quad end marker misplaced")
  `GQTL_ASSERT_NXT(a_quad_cont, out_valid && !out_stall && !out_word.quad_last, out_valid, "quad cut short")
  `GQTL_ASSERT_RST(a_rst_idle, !rst_n, !out_valid, "vertex word valid after reset")

endmodule

bind glyph_quad_text_layout_top gqtl_checker u_gqtl_checker (.*);
